// ===== rtl/core/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared widths, types and constants for the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int unsigned TRACK_W   = 16;
  localparam int unsigned TOTAL_W   = 21;
  localparam int unsigned DEPTH_DEF = 32;

  typedef logic [TRACK_W-1:0] track_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // running total saturates here
  localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// ===== rtl/core/sstf_if.sv =====
// ----------------------------------------------------------------------------
// sstf_if
// Request and result channels of the seek scheduler (valid/ready handshake).
// ----------------------------------------------------------------------------

// request channel: one track request per item
interface sstf_req_if;
  import sstf_pkg::*;

  logic   valid;
  logic   ready;
  track_t track;
  logic   last_request;

  modport source (output valid, track, last_request, input ready);
  modport sink   (input valid, track, last_request, output ready);
endinterface

// result channel: one served request per item
interface sstf_res_if;
  import sstf_pkg::*;

  logic   valid;
  logic   ready;
  track_t served_track;
  track_t seek_distance;
  total_t total_distance;
  logic   dropped;
  logic   last_result;

  modport source (output valid, served_track, seek_distance, total_distance, dropped,
                  last_result, input ready);
  modport sink   (input valid, served_track, seek_distance, total_distance, dropped,
                  last_result, output ready);
endinterface

// ===== rtl/core/sstf_seek_scheduler.sv =====
// ----------------------------------------------------------------------------
// sstf_seek_scheduler
// Shortest-seek-time-first disk request scheduler. Requests are loaded one
// item per cycle into a DEPTH-entry store; the item flagged last_request
// closes the job and starts service. Each result gives the served track,
// the seek distance from the previous head position and the running total;
// the final result of the job carries last_result. Ties on distance go to
// the earliest loaded request. Requests beyond DEPTH are discarded and
// reported through the dropped flag on every result of that job. The head
// starts each job at head_start (config port, write only while idle).
// Service: each result scans the store, one store read per cycle through
// the single read port into one shared distance compare unit, then
// commits the pick and waits in the output register until taken. The
// request channel is not ready from the closing item until the last
// result is taken.
// ----------------------------------------------------------------------------
module sstf_seek_scheduler #(
  parameter int unsigned DEPTH = sstf_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sstf_req_if.sink          in_ch,
  sstf_res_if.source        out_ch,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  sstf_pkg::track_t  cfg_data
);
  import sstf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  function automatic track_t gap(input track_t a, input track_t b);
    gap = (a > b) ? (a - b) : (b - a);
  endfunction

  // control and state registers
  logic [1:0]       state_r,   state_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;
  logic [CNT_W-1:0] scan_r,    scan_nxt;
  logic [CNT_W-1:0] step_r,    step_nxt;
  logic [DEPTH-1:0] marks_r,   marks_nxt;
  logic             ovf_r,     ovf_nxt;
  logic             found_r,   found_nxt;
  logic             rd_vld_r,  rd_vld_nxt;
  track_t           head_r,    head_nxt;
  track_t           hstart_r,  hstart_nxt;
  total_t           total_r,   total_nxt;

  // compare unit and output payload registers
  track_t           best_r,    best_nxt;
  track_t           ptrk_r,    ptrk_nxt;
  logic [IDX_W-1:0] pick_r,    pick_nxt;
  track_t           o_trk_r,   o_trk_nxt;
  track_t           o_seek_r,  o_seek_nxt;
  total_t           o_total_r, o_total_nxt;
  logic             o_drop_r,  o_drop_nxt;
  logic             o_last_r,  o_last_nxt;

  // request store
  track_t           mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  track_t           rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;

  // shared compare unit
  track_t           cand_gap;
  logic             cand_take;
  logic [TOTAL_W:0] total_sum;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = (state_r == ST_EMIT);
  assign out_ch.served_track   = o_trk_r;
  assign out_ch.seek_distance  = o_seek_r;
  assign out_ch.total_distance = o_total_r;
  assign out_ch.dropped        = o_drop_r;
  assign out_ch.last_result    = o_last_r;
  assign cfg_ready             = 1'b1;

  assign cand_gap  = gap(rd_data_r, head_r);
  assign cand_take = rd_vld_r && !marks_r[rd_idx_r] && (!found_r || (cand_gap < best_r));
  assign total_sum = {1'b0, total_r} + {{(TOTAL_W + 1 - TRACK_W){1'b0}}, best_r};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    step_nxt    = step_r;
    marks_nxt   = marks_r;
    ovf_nxt     = ovf_r;
    found_nxt   = found_r;
    rd_vld_nxt  = 1'b0;
    head_nxt    = head_r;
    hstart_nxt  = hstart_r;
    total_nxt   = total_r;
    best_nxt    = best_r;
    ptrk_nxt    = ptrk_r;
    pick_nxt    = pick_r;
    o_trk_nxt   = o_trk_r;
    o_seek_nxt  = o_seek_r;
    o_total_nxt = o_total_r;
    o_drop_nxt  = o_drop_r;
    o_last_nxt  = o_last_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[IDX_W-1:0];
    rd_en       = 1'b0;
    rd_addr     = scan_r[IDX_W-1:0];

    if (cfg_valid) begin
      hstart_nxt = cfg_data;
    end

    // fold the registered store read into the running best
    if (cand_take) begin
      found_nxt = 1'b1;
      best_nxt  = cand_gap;
      ptrk_nxt  = rd_data_r;
      pick_nxt  = rd_idx_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (cnt_r < CNT_W'(DEPTH)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_request) begin
            head_nxt  = hstart_r;
            step_nxt  = '0;
            scan_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_r != cnt_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          scan_nxt   = scan_r + CNT_W'(1);
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        marks_nxt[pick_r] = 1'b1;
        head_nxt          = ptrk_r;
        total_nxt         = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                           : total_sum[TOTAL_W-1:0];
        o_trk_nxt         = ptrk_r;
        o_seek_nxt        = best_r;
        o_total_nxt       = total_nxt;
        o_drop_nxt        = ovf_r;
        o_last_nxt        = ((step_r + CNT_W'(1)) == cnt_r);
        step_nxt          = step_r + CNT_W'(1);
        state_nxt         = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          if (o_last_r) begin
            marks_nxt = '0;
            cnt_nxt   = '0;
            total_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            scan_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      scan_r   <= '0;
      step_r   <= '0;
      marks_r  <= '0;
      ovf_r    <= 1'b0;
      found_r  <= 1'b0;
      rd_vld_r <= 1'b0;
      head_r   <= '0;
      hstart_r <= '0;
      total_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      scan_r   <= scan_nxt;
      step_r   <= step_nxt;
      marks_r  <= marks_nxt;
      ovf_r    <= ovf_nxt;
      found_r  <= found_nxt;
      rd_vld_r <= rd_vld_nxt;
      head_r   <= head_nxt;
      hstart_r <= hstart_nxt;
      total_r  <= total_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    ptrk_r    <= ptrk_nxt;
    pick_r    <= pick_nxt;
    o_trk_r   <= o_trk_nxt;
    o_seek_r  <= o_seek_nxt;
    o_total_r <= o_total_nxt;
    o_drop_r  <= o_drop_nxt;
    o_last_r  <= o_last_nxt;
  end

  // request store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_ch.track;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

`ifndef SYNTH
  // no new request while a result is pending
  a_no_load_during_service: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("request channel ready while a result is pending");

  // the total always covers the last seek
  a_total_covers_seek: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.total_distance >= {{(TOTAL_W - TRACK_W){1'b0}},
                                                out_ch.seek_distance}))
    else $error("running total below seek distance");

  // never serve more results than stored requests
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((step_r <= cnt_r) && (step_r != '0)))
    else $error("served count outside stored count");

  // job state is cleared once the final result is taken
  a_job_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_result) |=>
      ((cnt_r == '0) && (marks_r == '0) && (total_r == '0) && in_ch.ready))
    else $error("job state not cleared after final result");
`endif

endmodule
